// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/dcfg_pkg.sv -----
// Types, constants and helper functions of the despeckle filter.
`default_nettype none

package dcfg_pkg;

  localparam int unsigned MAX_WIDTH      = 32;
  localparam int unsigned MAX_HEIGHT     = 1024;
  localparam int unsigned COL_W          = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W          = $clog2(MAX_HEIGHT);
  localparam int unsigned WIDTH_MIN      = 2;
  localparam int unsigned HEIGHT_MIN     = 2;

  localparam int unsigned LEVEL_W        = 4;
  localparam int unsigned LEVEL_MAX      = 9;
  localparam int unsigned GLYPH_W        = 7;
  localparam int unsigned GLYPH_COUNT    = 10;
  localparam logic [GLYPH_COUNT*8-1:0] GLYPH_STR = " .':~*=&%#";

  localparam int unsigned LINE_WIDTH_W   = 6;
  localparam int unsigned FRAME_HEIGHT_W = 11;
  localparam int unsigned THRESH_W       = 4;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 11;

  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 6'd30;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 11'd20;
  localparam logic [THRESH_W-1:0]       THRESH_RST       = 4'd1;

  // power of two, pointers wrap naturally
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam int unsigned SUM_W          = LEVEL_W + 2;
  localparam int unsigned DIV3_MUL       = 11;
  localparam int unsigned DIV3_SHIFT     = 5;
  localparam int unsigned PROD_W         = SUM_W + DIV3_SHIFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_DIFF_THRESHOLD = 2'd2
  } cfg_idx_e;

  // One unit of work for the back end: a pixel (writes the stores) or a flush step.
  typedef struct packed {
    logic               wr;
    logic               emit;
    logic [COL_W-1:0]   col;
    logic               has_up;
    logic               has_left;
    logic               has_right;
    logic               row_end;
    logic               run_last;
    logic [LEVEL_W-1:0] lvl;
  } op_t;

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] lv);
    return (lv > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : lv;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W-1:0] k;
    k = sat_level(lv);
    return GLYPH_STR[(GLYPH_COUNT - 1 - int'(k)) * 8 +: GLYPH_W];
  endfunction

  // nb/has order: up, down, left, right
  function automatic logic [LEVEL_W-1:0] despeckle(
    input logic [LEVEL_W-1:0]        center,
    input logic [3:0]                has,
    input logic [3:0][LEVEL_W-1:0]   nb,
    input logic [THRESH_W-1:0]       thr
  );
    logic [SUM_W-1:0]   sum;
    logic [2:0]         cnt;
    logic               all_far;
    logic [LEVEL_W-1:0] diff;
    logic [PROD_W-1:0]  prod;
    logic [LEVEL_W-1:0] res;
    int                 k;
    sum     = '0;
    cnt     = '0;
    all_far = 1'b1;
    for (k = 0; k < 4; k++) begin
      if (has[k]) begin
        sum  = sum + SUM_W'(nb[k]);
        cnt  = cnt + 3'd1;
        diff = (center > nb[k]) ? center - nb[k] : nb[k] - center;
        if (diff <= thr) all_far = 1'b0;
      end
    end
    // sum/3 for sum <= 27 as (sum*11)>>5
    prod = PROD_W'(PROD_W'(sum) * PROD_W'(DIV3_MUL));
    case (cnt)
      3'd2:    res = sum[LEVEL_W:1];
      3'd3:    res = prod[DIV3_SHIFT +: LEVEL_W];
      3'd4:    res = sum[LEVEL_W+1:2];
      default: res = center;
    endcase
    if (!all_far) res = center;
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dcfg_cfg_if.sv -----
// Register write channel.
`default_nettype none

interface dcfg_cfg_if import dcfg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dcfg_pix_if.sv -----
// Pixel input stream.
`default_nettype none

interface dcfg_pix_if import dcfg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] pixel_level;

  modport source (output valid, output pixel_level, input ready);
  modport sink   (input valid, input pixel_level, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dcfg_res_if.sv -----
// Filtered result stream.
`default_nettype none

interface dcfg_res_if import dcfg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] filtered_level;
  logic [GLYPH_W-1:0] glyph_code;
  logic               row_end;
  logic               run_last;

  modport source (output valid, output filtered_level, output glyph_code,
                  output row_end, output run_last, input ready);
  modport sink   (input valid, input filtered_level, input glyph_code,
                  input row_end, input run_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dcfg_queue.sv -----
// Short op queue between the front end and the back end.
`default_nettype none

module dcfg_queue import dcfg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  op_t  in_op_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output op_t  out_op_o
);

  op_t               ops_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_op_o    = ops_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) cnt_d = cnt_q + (QPTR_W+1)'(1);
    else if (pop && !push) cnt_d = cnt_q - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ops_q[wr_ptr_q] <= in_op_i;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dcfg_front.sv -----
// Front end: config registers, raster position, pixel classification, row flush.
`default_nettype none

module dcfg_front import dcfg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  dcfg_cfg_if.sink            cfg_i,
  dcfg_pix_if.sink            pix_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output op_t                 q_op_o,
  output logic [THRESH_W-1:0] diff_threshold_o
);

  logic [LINE_WIDTH_W-1:0]   line_width_q, line_width_d;
  logic [FRAME_HEIGHT_W-1:0] frame_height_q, frame_height_d;
  logic [THRESH_W-1:0]       diff_threshold_q, diff_threshold_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic                      flushing_q, flushing_d;
  logic [COL_W-1:0]          fcol_q, fcol_d;

  logic [LINE_WIDTH_W-1:0]   eff_w;
  logic [FRAME_HEIGHT_W-1:0] eff_h;
  logic [COL_W-1:0]          c;
  logic [ROW_W-1:0]          r;
  logic                      last_col, last_row, flush_last;
  logic                      pix_acc, cfg_acc;
  op_t                       pix_op, flush_op;

  assign cfg_i.ready      = 1'b1;
  assign cfg_acc          = cfg_i.valid;
  assign pix_i.ready      = !flushing_q && q_ready_i;
  assign pix_acc          = pix_i.valid && pix_i.ready;
  assign diff_threshold_o = diff_threshold_q;

  always_comb begin
    if (line_width_q < LINE_WIDTH_W'(WIDTH_MIN)) eff_w = LINE_WIDTH_W'(WIDTH_MIN);
    else if (line_width_q > LINE_WIDTH_W'(MAX_WIDTH)) eff_w = LINE_WIDTH_W'(MAX_WIDTH);
    else eff_w = line_width_q;

    if (frame_height_q < FRAME_HEIGHT_W'(HEIGHT_MIN)) eff_h = FRAME_HEIGHT_W'(HEIGHT_MIN);
    else if (frame_height_q > FRAME_HEIGHT_W'(MAX_HEIGHT)) eff_h = FRAME_HEIGHT_W'(MAX_HEIGHT);
    else eff_h = frame_height_q;

    c = (LINE_WIDTH_W'(col_q) >= eff_w) ? COL_W'(eff_w - LINE_WIDTH_W'(1)) : col_q;
    r = (FRAME_HEIGHT_W'(row_q) >= eff_h) ? ROW_W'(eff_h - FRAME_HEIGHT_W'(1)) : row_q;

    last_col   = (LINE_WIDTH_W'(c) + LINE_WIDTH_W'(1)) == eff_w;
    last_row   = (FRAME_HEIGHT_W'(r) + FRAME_HEIGHT_W'(1)) == eff_h;
    flush_last = (LINE_WIDTH_W'(fcol_q) + LINE_WIDTH_W'(1)) == eff_w;
  end

  // pixel at (r, c) emits row r-1; its own result is not the last of the
  // beat when it also starts the last-row flush
  always_comb begin
    pix_op.wr        = 1'b1;
    pix_op.emit      = (r != '0);
    pix_op.col       = c;
    pix_op.has_up    = (r > ROW_W'(1));
    pix_op.has_left  = (c != '0);
    pix_op.has_right = !last_col;
    pix_op.row_end   = last_col;
    pix_op.run_last  = !(last_row && last_col);
    pix_op.lvl       = sat_level(pix_i.pixel_level);

    flush_op.wr        = 1'b0;
    flush_op.emit      = 1'b1;
    flush_op.col       = fcol_q;
    flush_op.has_up    = 1'b1;
    flush_op.has_left  = (fcol_q != '0);
    flush_op.has_right = !flush_last;
    flush_op.row_end   = flush_last;
    flush_op.run_last  = flush_last;
    flush_op.lvl       = '0;
  end

  assign q_valid_o = flushing_q || pix_i.valid;
  assign q_op_o    = flushing_q ? flush_op : pix_op;

  always_comb begin
    line_width_d     = line_width_q;
    frame_height_d   = frame_height_q;
    diff_threshold_d = diff_threshold_q;
    col_d            = col_q;
    row_d            = row_q;
    flushing_d       = flushing_q;
    fcol_d           = fcol_q;

    if (flushing_q && q_ready_i) begin
      fcol_d = fcol_q + COL_W'(1);
      if (flush_last) flushing_d = 1'b0;
    end

    if (pix_acc) begin
      if (last_row && last_col) begin
        col_d      = '0;
        row_d      = '0;
        flushing_d = 1'b1;
        fcol_d     = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = r + ROW_W'(1);
      end else begin
        col_d = c + COL_W'(1);
        row_d = r;
      end
    end

    // any write to a known register restarts the frame
    if (cfg_acc) begin
      unique case (cfg_i.reg_index)
        CFG_LINE_WIDTH: begin
          line_width_d = cfg_i.wr_data[LINE_WIDTH_W-1:0];
          col_d        = '0;
          row_d        = '0;
        end
        CFG_FRAME_HEIGHT: begin
          frame_height_d = cfg_i.wr_data[FRAME_HEIGHT_W-1:0];
          col_d          = '0;
          row_d          = '0;
        end
        CFG_DIFF_THRESHOLD: begin
          diff_threshold_d = cfg_i.wr_data[THRESH_W-1:0];
          col_d            = '0;
          row_d            = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q     <= LINE_WIDTH_RST;
      frame_height_q   <= FRAME_HEIGHT_RST;
      diff_threshold_q <= THRESH_RST;
      col_q            <= '0;
      row_q            <= '0;
      flushing_q       <= 1'b0;
      fcol_q           <= '0;
    end else begin
      line_width_q     <= line_width_d;
      frame_height_q   <= frame_height_d;
      diff_threshold_q <= diff_threshold_d;
      col_q            <= col_d;
      row_q            <= row_d;
      flushing_q       <= flushing_d;
      fcol_q           <= fcol_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dcfg_back.sv -----
// Back end: line stores, neighbour fetch, despeckle and output register.
`default_nettype none

module dcfg_back import dcfg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  op_t                 op_i,
  output logic                op_pop_o,
  input  logic [THRESH_W-1:0] diff_threshold_i,
  dcfg_res_if.source          res_o
);

  logic [LEVEL_W-1:0] recent_mem [MAX_WIDTH];
  logic [LEVEL_W-1:0] older_mem  [MAX_WIDTH];

  logic               s2_valid_q, s2_valid_d;
  op_t                s2_op_q;
  logic [LEVEL_W-1:0] cen_q, rgt_q, up_q, left_q;

  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] out_level_q;
  logic [GLYPH_W-1:0] out_glyph_q;
  logic               out_row_end_q, out_run_last_q;

  logic               out_free, s2_fire, s2_load, mem_we;
  logic [COL_W-1:0]   wr_addr, rd_a, rd_b;
  logic [3:0]         has;
  logic [3:0][LEVEL_W-1:0] nb;
  logic [LEVEL_W-1:0] level;

  assign out_free = !out_valid_q || res_o.ready;
  assign s2_fire  = s2_valid_q && (!s2_op_q.emit || out_free);
  assign s2_load  = op_valid_i && (!s2_valid_q || s2_fire);
  assign op_pop_o = s2_load;

  assign mem_we  = s2_fire && s2_op_q.wr;
  assign wr_addr = s2_op_q.col;
  assign rd_a    = op_i.col;
  assign rd_b    = op_i.col + COL_W'(1);

  // left neighbour is always the previous op's center
  assign has = {s2_op_q.has_right, s2_op_q.has_left, s2_op_q.wr, s2_op_q.has_up};
  assign nb  = {rgt_q, left_q, s2_op_q.lvl, up_q};
  assign level = sat_level(despeckle(cen_q, has, nb, diff_threshold_i));

  // stores: write at retire, read at issue with write-first bypass
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      recent_mem[wr_addr] <= s2_op_q.lvl;
      older_mem[wr_addr]  <= cen_q;
    end
    if (s2_load) begin
      s2_op_q <= op_i;
      cen_q   <= (mem_we && wr_addr == rd_a) ? s2_op_q.lvl : recent_mem[rd_a];
      rgt_q   <= (mem_we && wr_addr == rd_b) ? s2_op_q.lvl : recent_mem[rd_b];
      up_q    <= (mem_we && wr_addr == rd_a) ? cen_q : older_mem[rd_a];
    end
    if (s2_fire) left_q <= cen_q;
    if (s2_fire && s2_op_q.emit) begin
      out_level_q    <= level;
      out_glyph_q    <= glyph_of(level);
      out_row_end_q  <= s2_op_q.row_end;
      out_run_last_q <= s2_op_q.run_last;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s2_load) s2_valid_d = 1'b1;
    else if (s2_fire) s2_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (s2_fire && s2_op_q.emit) out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.filtered_level = out_level_q;
  assign res_o.glyph_code     = out_glyph_q;
  assign res_o.row_end        = out_row_end_q;
  assign res_o.run_last       = out_run_last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/despeckle_cross_filter_to_glyph_unit.sv -----
// Four-neighbour impulse-noise filter with glyph output. Pixels (levels 0..9, higher
// values saturate to 9) enter one per clock in raster order while input ready is high;
// results leave one row behind, each giving the filtered level, its darkness glyph, a
// row-end flag and a flag on the last result of the input beat. A pixel that differs
// by more than diff_threshold from all its in-frame up/down/left/right neighbours
// becomes their truncated mean. Sustained rate is one pixel per cycle while the output
// does not stall; the last pixel of a frame is followed by the flush of the last row,
// one step per pixel of the row in use (line_width after clamping to 2..32), with
// input ready low while the front end issues it. A result passes through the op queue,
// the store read stage and the output register, and the flush results follow one per
// cycle while the output does not stall. The line stores need no clearing after reset.
// Write configuration only while the block is idle; any write to a known register
// restarts the frame position, store contents are kept.
`default_nettype none

module despeckle_cross_filter_to_glyph_unit import dcfg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcfg_cfg_if.sink   cfg_i,
  dcfg_pix_if.sink   pix_i,
  dcfg_res_if.source res_o
);

  logic                fq_valid, fq_ready;
  op_t                 fq_op;
  logic                qb_valid, qb_pop;
  op_t                 qb_op;
  logic [THRESH_W-1:0] diff_threshold;

  dcfg_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_i),
    .pix_i            (pix_i),
    .q_valid_o        (fq_valid),
    .q_ready_i        (fq_ready),
    .q_op_o           (fq_op),
    .diff_threshold_o (diff_threshold)
  );

  dcfg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_op_i     (fq_op),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_pop),
    .out_op_o    (qb_op)
  );

  dcfg_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_valid_i       (qb_valid),
    .op_i             (qb_op),
    .op_pop_o         (qb_pop),
    .diff_threshold_i (diff_threshold),
    .res_o            (res_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/dcfg_checker.sv -----
// Port-level checker for the despeckle filter, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module dcfg_checker import dcfg_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [LEVEL_W-1:0] filtered_level_i,
  input logic [GLYPH_W-1:0] glyph_code_i,
  input logic               row_end_i,
  input logic               run_last_i
);

  // a stalled result beat holds
  `ASSERT_NXT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({filtered_level_i, glyph_code_i, row_end_i, run_last_i}))

  `ASSERT_IMP(a_level_range, clk_i, rst_ni, out_valid_i, filtered_level_i <= LEVEL_W'(LEVEL_MAX))

  `ASSERT_IMP(a_glyph_match, clk_i, rst_ni, out_valid_i, glyph_code_i == glyph_of(filtered_level_i))

endmodule

bind despeckle_cross_filter_to_glyph_unit dcfg_checker u_dcfg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .filtered_level_i (res_o.filtered_level),
  .glyph_code_i     (res_o.glyph_code),
  .row_end_i        (res_o.row_end),
  .run_last_i       (res_o.run_last)
);

`default_nettype wire
